FILE: rtl/sdae_pkg.sv
// ----------------------------------------------------------------------------
// sdae_pkg: shared constants and types for the signed decimal ASCII emitter
// Widths of the magnitude and BCD registers, character codes, control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package sdae_pkg;

    localparam int VALUE_BITS = 32;

    // Magnitude bits consumed per shift-add-3 iteration.
    localparam int STEP_BITS  = 2;
    localparam int CONV_STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int MAG_W      = CONV_STEPS * STEP_BITS;

    // Decimal digits needed for any magnitude up to 2**(VALUE_BITS-1).
    localparam int NDIG       = (VALUE_BITS * 301) / 1000 + 1;
    localparam int BCD_W      = NDIG * 4;
    localparam int CNT_W      = $clog2(NDIG + 1);
    localparam int STEP_CNT_W = $clog2(CONV_STEPS + 1);

    localparam logic [5:0] CH_MINUS = 6'd45;
    localparam logic [5:0] CH_DOT   = 6'd46;
    localparam logic [5:0] CH_ZERO  = 6'd48;

    localparam logic OP_INTEGER    = 1'b0;
    localparam logic OP_HUNDREDTHS = 1'b1;

    typedef struct packed {
        logic load;         // take a new magnitude, clear the digits
        logic step;         // one shift-add-3 iteration
        logic shift_digit;  // drop the top digit, advance the next one up
    } sdae_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/sdae_in_if.sv
// ----------------------------------------------------------------------------
// sdae_in_if: number request channel
// Carries the mode and the signed value to be printed.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdae_in_if;
    import sdae_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/sdae_out_if.sv
// ----------------------------------------------------------------------------
// sdae_out_if: character request channel
// Carries one ASCII character and the end-of-text mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdae_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/sdae_bcd_core.sv
// ----------------------------------------------------------------------------
// sdae_bcd_core: iterative binary to BCD unit
// Shift-add-3 over STEP_BITS bits a cycle; also shifts digits out top first.
// ----------------------------------------------------------------------------
`default_nettype none

module sdae_bcd_core (
    input  wire logic                      clk,
    input  wire sdae_pkg::sdae_ctrl_t      ctrl,
    input  wire logic [sdae_pkg::VALUE_BITS-1:0] mag,
    output logic [3:0]                     top_digit
);
    import sdae_pkg::*;

    logic [MAG_W-1:0] bin_reg;
    logic [MAG_W-1:0] bin_next;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [MAG_W-1:0] bin_step;
    logic [BCD_W-1:0] bcd_step;

    // STEP_BITS rounds of: correct every digit, then shift one bit in.
    always_comb
    begin
        logic [BCD_W-1:0] b;
        logic [MAG_W-1:0] m;
        b = bcd_reg;
        m = bin_reg;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (b[d*4 +: 4] >= 4'd5)
                begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], m[MAG_W-1]};
            m = {m[MAG_W-2:0], 1'b0};
        end
        bcd_step = b;
        bin_step = m;
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.load)
        begin
            bin_next = MAG_W'(mag);
            bcd_next = '0;
        end
        else if (ctrl.step)
        begin
            bin_next = bin_step;
            bcd_next = bcd_step;
        end
        else if (ctrl.shift_digit)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'b0000};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

endmodule

`default_nettype wire

FILE: rtl/signed_decimal_ascii_emitter_unit.sv
// ----------------------------------------------------------------------------
// signed_decimal_ascii_emitter_unit: signed value to ASCII decimal text
// Prints a signed value as an integer or as hundredths, one char per request.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | request moves
//  number  | in  | operation (1), value (32 signed) | one value to print
//  text    | out | char_code (6), last (1)          | one ASCII character
//
//  A value runs through the shift-add-3 unit two bits a cycle, then the trim
//  state drops up to NDIG-3 (hundredths) or NDIG-1 (integer) leading zero
//  digits, one digit a cycle, until it finds the top digit to keep, then
//  sends one character per cycle while text is ready.
//  number.ready is high only while the sequencer is idle; the last character
//  may still wait in the output register while the next value is taken.
//  A stall on text holds the output register and, while emitting, the sequencer.
//  rst_n clears the sequencer and the output valid; data registers keep.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_ascii_emitter_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sdae_in_if.sink    number,
    sdae_out_if.source text
);
    import sdae_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_TRIM = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [STEP_CNT_W-1:0] step_cnt_reg;
    logic [STEP_CNT_W-1:0] step_cnt_next;
    logic [CNT_W-1:0]      dig_cnt_reg;
    logic [CNT_W-1:0]      dig_cnt_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic                  dot_reg;
    logic                  dot_next;
    logic                  op_reg;
    logic                  op_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [5:0]            out_char_reg;
    logic [5:0]            out_char_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    logic                  accept;
    logic                  out_free;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic [CNT_W-1:0]      min_digits;
    logic [3:0]            top_digit;
    sdae_ctrl_t            ctrl;

    assign accept   = number.valid && number.ready;
    assign out_free = !out_valid_reg || text.ready;

    // Magnitude as unsigned, so the most negative value wraps to itself.
    assign in_neg = number.value[VALUE_BITS-1];
    assign in_mag = in_neg ? (~VALUE_BITS'(number.value) + 1'b1)
                           : VALUE_BITS'(number.value);

    // Keep one whole digit plus both fraction digits in hundredths mode.
    assign min_digits = (op_reg == OP_HUNDREDTHS) ? CNT_W'(3) : CNT_W'(1);

    sdae_bcd_core u_bcd (
        .clk       (clk),
        .ctrl      (ctrl),
        .mag       (in_mag),
        .top_digit (top_digit)
    );

    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        neg_next       = neg_reg;
        dot_next       = dot_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !text.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        ctrl           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load     = 1'b1;
                    op_next       = number.operation;
                    neg_next      = in_neg;
                    dot_next      = number.operation;
                    step_cnt_next = STEP_CNT_W'(CONV_STEPS);
                    dig_cnt_next  = CNT_W'(NDIG);
                    state_next    = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.step     = 1'b1;
                step_cnt_next = step_cnt_reg - 1'b1;
                if (step_cnt_reg == STEP_CNT_W'(1))
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                // Drop leading zero digits down to the minimum count.
                if (top_digit == 4'd0 && dig_cnt_reg > min_digits)
                begin
                    ctrl.shift_digit = 1'b1;
                    dig_cnt_next     = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b0;
                    if (neg_reg)
                    begin
                        out_char_next = CH_MINUS;
                        neg_next      = 1'b0;
                    end
                    else if (dot_reg && dig_cnt_reg == CNT_W'(2))
                    begin
                        out_char_next = CH_DOT;
                        dot_next      = 1'b0;
                    end
                    else
                    begin
                        out_char_next    = {2'b11, top_digit};
                        ctrl.shift_digit = 1'b1;
                        dig_cnt_next     = dig_cnt_reg - 1'b1;
                        if (dig_cnt_reg == CNT_W'(1))
                        begin
                            out_last_next = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_cnt_reg <= step_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        neg_reg      <= neg_next;
        dot_reg      <= dot_next;
        op_reg       <= op_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign number.ready   = (state_reg == ST_IDLE);
    assign text.valid     = out_valid_reg;
    assign text.char_code = out_char_reg;
    assign text.last      = out_last_reg;

    // A taken value always starts the conversion.
    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_CONV)
        else $error("accepted value did not start conversion");

    // Digits never run out while characters remain to be sent.
    a_emit_digits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> dig_cnt_reg != '0)
        else $error("digit count empty during emission");

    // Trimming never goes below the mode's minimum digit count.
    a_trim_floor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TRIM |-> dig_cnt_reg >= min_digits)
        else $error("leading zero trim removed too many digits");

    // The final character of every text is a digit.
    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && text.last |-> text.char_code >= CH_ZERO)
        else $error("last character is not a digit");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for signed_decimal_ascii_emitter_unit
// Sends signed values in integer and hundredths mode over the number channel.
// Each accepted request is turned into the text it should print, one character
// at a time. Every character on the text channel is checked against the oldest
// one still waiting. A short table of directed rows comes first, then random
// values. Both channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdae_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_SPAN    = 32;
    // Worst case per value is 16 conversion steps, 9 leading-zero drops
    // and 12 characters, each behind a random stall, plus a random gap.
    // CYCLE_LIMIT leaves a wide margin over what 472 values need.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 48;

    typedef logic signed [VALUE_BITS-1:0] number_t;

    // One character expected on the text channel.
    typedef struct packed {
        logic [5:0] char_code;
        logic       last;
    } text_char_t;

    // One directed row. An empty text means the character predictor decides.
    typedef struct {
        logic    operation;
        number_t value;
        string   text;
    } number_row_t;

    localparam int DIRECTED_ROWS = 22;

    number_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_INTEGER,    32'sd0,           "0"},
        '{OP_HUNDREDTHS, 32'sd0,           "0.00"},
        '{OP_INTEGER,    32'sh7FFF_FFFF,   "2147483647"},
        '{OP_HUNDREDTHS, 32'sh7FFF_FFFF,   "21474836.47"},
        '{OP_INTEGER,    32'sh8000_0000,   "-2147483648"},
        '{OP_HUNDREDTHS, 32'sh8000_0000,   "-21474836.48"},
        '{OP_INTEGER,    -32'sd1,          "-1"},
        '{OP_HUNDREDTHS, -32'sd1,          "-0.01"},
        '{OP_HUNDREDTHS, -32'sd5,          "-0.05"},
        '{OP_HUNDREDTHS, 32'sd5,           "0.05"},
        '{OP_HUNDREDTHS, 32'sd100,         "1.00"},
        '{OP_HUNDREDTHS, -32'sd100,        "-1.00"},
        '{OP_INTEGER,    32'sd1,           "1"},
        '{OP_INTEGER,    32'sd9,           ""},
        '{OP_INTEGER,    32'sd10,          ""},
        '{OP_INTEGER,    -32'sd10,         ""},
        '{OP_HUNDREDTHS, 32'sd99,          ""},
        '{OP_HUNDREDTHS, -32'sd99,         ""},
        '{OP_HUNDREDTHS, 32'sd101,         ""},
        '{OP_INTEGER,    32'sd1000000000,  ""},
        '{OP_INTEGER,    -32'sd999999999,  ""},
        '{OP_HUNDREDTHS, 32'sd12345,       ""}
    };

    logic clk;
    logic rst_n;

    sdae_in_if  number_if ();
    sdae_out_if text_if ();

    signed_decimal_ascii_emitter_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_if),
        .text   (text_if)
    );

    // Characters still owed by the block, oldest first.
    text_char_t pending_chars [$];
    // Scratch text built by the predictor for one value.
    logic [5:0] digit_buf [$];

    int  fail_count   = 0;
    int  cycle_count  = 0;
    bit  sender_calm  = 1'b0;
    bit  receiver_calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Hard stop: a hung handshake must not hang the run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // Append the decimal digits of an unsigned magnitude, most significant
    // first; zero gives a single '0'.
    function automatic void append_decimal(input logic [VALUE_BITS-1:0] mag);
        logic [VALUE_BITS-1:0] rest;
        logic [VALUE_BITS-1:0] digit;
        logic [5:0]            reversed [$];
        rest = mag;
        do
        begin
            digit = rest % 10;
            reversed.push_front(CH_ZERO + digit[5:0]);
            rest = rest / 10;
        end
        while (rest != 0);
        foreach (reversed[i])
            digit_buf.push_back(reversed[i]);
    endfunction

    // Build the text of one value and queue it as expected characters.
    function automatic void predict_text(input logic operation, input number_t value);
        logic                  negative;
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] frac;
        text_char_t            ch;
        digit_buf.delete();
        negative = value[VALUE_BITS-1];
        // Unsigned negate keeps the most negative value intact.
        mag = negative ? (~value + 1'b1) : value;
        if (negative)
            digit_buf.push_back(CH_MINUS);
        if (operation == OP_INTEGER)
        begin
            append_decimal(mag);
        end
        else
        begin
            append_decimal(mag / 100);
            frac = mag % 100;
            digit_buf.push_back(CH_DOT);
            digit_buf.push_back(CH_ZERO + 6'(frac / 10));
            digit_buf.push_back(CH_ZERO + 6'(frac % 10));
        end
        foreach (digit_buf[i])
        begin
            ch.char_code = digit_buf[i];
            ch.last      = (i == digit_buf.size() - 1);
            pending_chars.push_back(ch);
        end
    endfunction

    // Queue a typed-in text as expected characters.
    function automatic void queue_typed_text(input string text);
        text_char_t ch;
        for (int i = 0; i < text.len(); i++)
        begin
            ch.char_code = 6'(text[i]);
            ch.last      = (i == text.len() - 1);
            pending_chars.push_back(ch);
        end
    endfunction

    // Offer one value on the number channel and hold it until accepted.
    // The expected text is queued at the edge that takes the request.
    task automatic offer_number(input logic operation, input number_t value,
                                input string typed_text);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            number_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        number_if.valid     <= 1'b1;
        number_if.operation <= operation;
        number_if.value     <= value;
        @(posedge clk);
        while (!(number_if.valid && number_if.ready))
            @(posedge clk);
        if (typed_text.len() != 0)
            queue_typed_text(typed_text);
        else
            predict_text(operation, value);
    endtask

    // Draw a value that spreads over the interesting corners: full random
    // bits, short numbers of either sign, the ends of the range, the
    // neighbors of powers of ten and numbers of up to seven digits of either sign.
    function automatic number_t pick_value();
        number_t     v;
        logic [31:0] p10;
        int          k;
        case ($urandom_range(0, 5))
            0: v = number_t'($urandom);
            1: v = number_t'($urandom_range(0, 999));
            2: v = -number_t'($urandom_range(0, 999));
            3:
            begin
                if ($urandom_range(0, 1) == 1)
                    v = 32'sh7FFF_FFFF - number_t'($urandom_range(0, 300));
                else
                    v = 32'sh8000_0000 + number_t'($urandom_range(0, 300));
            end
            4:
            begin
                p10 = 1;
                k   = $urandom_range(0, 9);
                repeat (k) p10 = p10 * 10;
                v = number_t'(p10) + number_t'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default:
            begin
                v = number_t'($urandom_range(0, 9999999));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // Text side: draw a stall before each character, then take and check it.
    initial
    begin
        int         stall;
        int         taken;
        text_char_t want;
        taken = 0;
        text_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % CALM_SPAN == 0)
                receiver_calm = ($urandom_range(0, 3) == 0);
            stall = receiver_calm ? 0 : $urandom_range(0, 3);
            if (stall != 0)
            begin
                text_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            text_if.ready <= 1'b1;
            @(posedge clk);
            while (!(text_if.valid && text_if.ready))
                @(posedge clk);
            taken++;
            if (pending_chars.size() == 0)
            begin
                $error("char_code: no character expected, got %0d (last %0b)",
                       text_if.char_code, text_if.last);
                fail_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (text_if.char_code !== want.char_code)
                begin
                    $error("char_code: expected %0d, got %0d",
                           want.char_code, text_if.char_code);
                    fail_count++;
                end
                if (text_if.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, text_if.last);
                    fail_count++;
                end
            end
        end
    end

    // Number side: reset, directed table, random values, drain, verdict.
    initial
    begin
        logic op;
        rst_n               <= 1'b0;
        number_if.valid     <= 1'b0;
        number_if.operation <= OP_INTEGER;
        number_if.value     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows go first; hold a steady pace for half of them so the
        // back-to-back case is covered early.
        foreach (directed_rows[i])
        begin
            sender_calm = (i < DIRECTED_ROWS / 2);
            offer_number(directed_rows[i].operation, directed_rows[i].value,
                         directed_rows[i].text);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % CALM_SPAN == 0)
                sender_calm = ($urandom_range(0, 3) == 0);
            op = ($urandom_range(0, 1) == 1) ? OP_HUNDREDTHS : OP_INTEGER;
            offer_number(op, pick_value(), "");
        end
        number_if.valid <= 1'b0;

        // Drain: wait for every owed character, then watch for strays.
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/sdae_pkg.sv
rtl/sdae_in_if.sv
rtl/sdae_out_if.sv
rtl/sdae_bcd_core.sv
rtl/signed_decimal_ascii_emitter_unit.sv
verif/tb.sv
